// ===== rtl/core/vertex_attribute_quantizer_core_assert.svh =====
// Assertion macros shared by the vertex attribute quantizer RTL.
`ifndef VERTEX_ATTRIBUTE_QUANTIZER_CORE_ASSERT_SVH
`define VERTEX_ATTRIBUTE_QUANTIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VAQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vertex attribute quantizer assertion failed");

// Next-cycle implication, disabled during reset.
`define VAQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vertex attribute quantizer assertion failed");

`endif

// ===== rtl/core/vaq_pkg.sv =====
// Package with the codes, widths and types of the vertex attribute quantizer.
`default_nettype none
package vaq_pkg;

  localparam logic [2:0] KIND_POS      = 3'd0;
  localparam logic [2:0] KIND_NORMAL   = 3'd1;
  localparam logic [2:0] KIND_TANGENT  = 3'd2;
  localparam logic [2:0] KIND_BINORMAL = 3'd3;
  localparam logic [2:0] KIND_TEXCOORD = 3'd4;

  localparam int NSTEP  = 8;
  localparam int ACC_W  = 85;
  localparam int A_W    = 78;
  localparam int NSTAGE = 14;

  typedef struct packed {
    logic [2:0]  kind;
    logic        two;
    logic [14:0] ba;
    logic [14:0] bb;
    logic [7:0]  wb;
    logic        zero;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] lz;
    logic [15:0] tu;
    logic [15:0] tv;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/core/vaq_nquant.sv =====
// Eight-stage exact byte search for one normalized vector component.
`default_nettype none
module vaq_nquant (
  input  logic                      clk,
  input  logic [vaq_pkg::NSTEP-1:0] en,
  input  logic [63:0]               s,
  input  logic [vaq_pkg::A_W-1:0]   a,
  input  logic                      neg,
  output logic [7:0]                k
);

  logic signed [vaq_pkg::ACC_W-1:0] p_r [vaq_pkg::NSTEP-1];
  logic signed [vaq_pkg::ACC_W-1:0] q_r [vaq_pkg::NSTEP-1];
  logic signed [vaq_pkg::ACC_W-1:0] s_r [vaq_pkg::NSTEP-1];
  logic signed [vaq_pkg::ACC_W-1:0] a_r [vaq_pkg::NSTEP-1];
  logic [7:0]                       m_r [vaq_pkg::NSTEP];
  logic                             neg_r [vaq_pkg::NSTEP];

  // Each stage tries one more bit of m, where the test is (2m-1)^2 * s against a.
  // P holds (2m-1)^2 * s and Q holds (2m-1) * s, so a step needs only shifts and adds.
  for (genvar j = 0; j < vaq_pkg::NSTEP; j++) begin : g_step
    logic signed [vaq_pkg::ACC_W-1:0] p_i, q_i, s_i, a_i, cand, q_nx;
    logic [7:0] m_i;
    logic       neg_i, acc;

    if (j == 0) begin : g_first
      assign s_i   = $signed({{(vaq_pkg::ACC_W-64){1'b0}}, s});
      assign a_i   = $signed({{(vaq_pkg::ACC_W-vaq_pkg::A_W){1'b0}}, a});
      assign p_i   = s_i;
      assign q_i   = -s_i;
      assign m_i   = 8'd0;
      assign neg_i = neg;
    end else begin : g_next
      assign s_i   = s_r[j-1];
      assign a_i   = a_r[j-1];
      assign p_i   = p_r[j-1];
      assign q_i   = q_r[j-1];
      assign m_i   = m_r[j-1];
      assign neg_i = neg_r[j-1];
    end

    assign cand = p_i + (q_i <<< (2 + 7 - j)) + (s_i <<< (2 + 2 * (7 - j)));
    assign q_nx = q_i + (s_i <<< (1 + 7 - j));
    assign acc  = neg_i ? (cand < a_i) : (cand <= a_i);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        neg_r[j] <= neg_i;
        m_r[j]   <= acc ? (m_i | (8'd1 << (7 - j))) : m_i;
      end
    end

    if (j < vaq_pkg::NSTEP - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          s_r[j] <= s_i;
          a_r[j] <= a_i;
          p_r[j] <= acc ? cand : p_i;
          q_r[j] <= acc ? q_nx : q_i;
        end
      end
    end
  end

  assign k = neg_r[vaq_pkg::NSTEP-1] ? 8'(8'd127 - m_r[vaq_pkg::NSTEP-1])
                                     : 8'(8'd127 + m_r[vaq_pkg::NSTEP-1]);

endmodule
`default_nettype wire

// ===== rtl/core/vertex_attribute_quantizer_core.sv =====
// Top level of the vertex attribute quantizer: pipeline, control and output packing.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------
//   input   | in_valid, in_ready  | kind, x, y, z, bone_a, bone_b, weight
//   output  | out_valid, out_ready| packed_res, wide
//   config  | cfg_we              | cfg_data (two_weight_mode)
//
// An item passes stages 0 to 13 to out_valid; one item enters per cycle while in_ready is high.
// Eight of those stages are the exact byte search of the vector components.
// Reset clears the stage valid bits and sets two_weight_mode to zero.
// A stalled output holds the last stage; empty stages ahead of it keep filling.
`default_nettype none
module vertex_attribute_quantizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  input  logic [14:0]        bone_a,
  input  logic [14:0]        bone_b,
  input  logic signed [31:0] weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        packed_res,
  output logic               wide
);

  logic two_weight_mode;
  logic [vaq_pkg::NSTAGE-1:0] v;
  logic [vaq_pkg::NSTAGE-1:0] en;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_weight_mode <= 1'b0;
    end else if (cfg_we) begin
      two_weight_mode <= cfg_data;
    end
  end

  always_comb begin
    en[vaq_pkg::NSTAGE-1] = !v[vaq_pkg::NSTAGE-1] || out_ready;
    for (int i = vaq_pkg::NSTAGE - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < vaq_pkg::NSTAGE; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  function automatic logic [17:0] pos_pre(input logic signed [47:0] pm);
    logic signed [47:0] sh;
    logic [17:0] u;
    sh = pm >>> 18;
    if (sh < -48'sd98304) begin
      u = 18'd0;
    end else if (sh > 48'sd98303) begin
      u = 18'd196607;
    end else begin
      u = 18'(sh + 48'sd98304);
    end
    return u;
  endfunction

  function automatic logic [15:0] tc_lane(input logic signed [47:0] pm);
    logic signed [47:0] sh;
    logic [15:0] l;
    sh = pm >>> 20;
    if (sh < -48'sd32768) begin
      l = 16'h8000;
    end else if (sh > 48'sd32767) begin
      l = 16'h7FFF;
    end else begin
      l = sh[15:0];
    end
    return l;
  endfunction

  function automatic logic [7:0] wt_byte(input logic signed [40:0] wm);
    logic signed [40:0] sh;
    logic [7:0] b;
    sh = wm >>> 16;
    if (sh < 41'sd0) begin
      b = 8'd0;
    end else if (sh > 41'sd255) begin
      b = 8'd255;
    end else begin
      b = sh[7:0];
    end
    return b;
  endfunction

  function automatic logic [31:0] mag(input logic signed [31:0] c);
    return c[31] ? 32'(-c) : 32'(c);
  endfunction

  // Stage 0: input registers.
  logic [2:0]         k0;
  logic               two0;
  logic signed [31:0] x0, y0, z0, w0;
  logic [14:0]        ba0, bb0;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      k0   <= kind;
      two0 <= two_weight_mode;
      x0   <= x;
      y0   <= y;
      z0   <= z;
      w0   <= weight;
      ba0  <= bone_a;
      bb0  <= bone_b;
    end
  end

  // Stage 1: magnitudes and constant products.
  logic [2:0]         k1;
  logic               two1;
  logic [14:0]        ba1, bb1;
  logic [31:0]        ax1, ay1, az1;
  logic               nx1, ny1, nz1;
  logic signed [47:0] pmx1, pmy1, pmz1;
  logic signed [40:0] wm1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      k1   <= k0;
      two1 <= two0;
      ba1  <= ba0;
      bb1  <= bb0;
      ax1  <= mag(x0);
      ay1  <= mag(y0);
      az1  <= mag(z0);
      nx1  <= x0[31];
      ny1  <= y0[31];
      nz1  <= z0[31];
      pmx1 <= 48'(x0) * 48'sd32767;
      pmy1 <= 48'(y0) * 48'sd32767;
      pmz1 <= 48'(z0) * 48'sd32767;
      wm1  <= 41'(w0) * 41'sd255 + 41'sd32768;
    end
  end

  // Stage 2: squares, clamps.
  logic [2:0]  k2;
  logic        two2;
  logic [14:0] ba2, bb2;
  logic [63:0] sqx2, sqy2, sqz2;
  logic        nx2, ny2, nz2;
  logic [17:0] ux2, uy2, uz2;
  logic [15:0] tu2, tv2;
  logic [7:0]  wb2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      k2   <= k1;
      two2 <= two1;
      ba2  <= ba1;
      bb2  <= bb1;
      sqx2 <= 64'(ax1) * 64'(ax1);
      sqy2 <= 64'(ay1) * 64'(ay1);
      sqz2 <= 64'(az1) * 64'(az1);
      nx2  <= nx1;
      ny2  <= ny1;
      nz2  <= nz1;
      ux2  <= pos_pre(pmx1);
      uy2  <= pos_pre(pmy1);
      uz2  <= pos_pre(pmz1);
      tu2  <= tc_lane(pmx1);
      tv2  <= tc_lane(pmy1);
      wb2  <= wt_byte(wm1);
    end
  end

  // Stage 3: squared length, partial products of the thresholds, position lanes.
  logic [2:0]  k3;
  logic        two3;
  logic [14:0] ba3, bb3;
  logic [7:0]  wb3;
  logic [15:0] tu3, tv3;
  logic [63:0] s3;
  logic [47:0] alx3, ahx3, aly3, ahy3, alz3, ahz3;
  logic        nx3, ny3, nz3;
  logic [15:0] lx3, ly3, lz3;
  logic [37:0] qx, qy, qz;

  assign qx = 38'(ux2) * 38'd349526;
  assign qy = 38'(uy2) * 38'd349526;
  assign qz = 38'(uz2) * 38'd349526;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      k3   <= k2;
      two3 <= two2;
      ba3  <= ba2;
      bb3  <= bb2;
      wb3  <= wb2;
      tu3  <= tu2;
      tv3  <= tv2;
      s3   <= sqx2 + sqy2 + sqz2;
      alx3 <= 48'(sqx2[31:0]) * 48'd65025;
      ahx3 <= 48'(sqx2[63:32]) * 48'd65025;
      aly3 <= 48'(sqy2[31:0]) * 48'd65025;
      ahy3 <= 48'(sqy2[63:32]) * 48'd65025;
      alz3 <= 48'(sqz2[31:0]) * 48'd65025;
      ahz3 <= 48'(sqz2[63:32]) * 48'd65025;
      nx3  <= nx2;
      ny3  <= ny2;
      nz3  <= nz2;
      lx3  <= qx[35:20] ^ 16'h8000;
      ly3  <= qy[35:20] ^ 16'h8000;
      lz3  <= qz[35:20] ^ 16'h8000;
    end
  end

  // Stage 4: thresholds 65025 * c^2 and the side data that rides along.
  vaq_pkg::side_t            sd [4:12];
  logic [63:0]               s4;
  logic [vaq_pkg::A_W-1:0]   ax4, ay4, az4;
  logic                      nx4, ny4, nz4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sd[4].kind <= k3;
      sd[4].two  <= two3;
      sd[4].ba   <= ba3;
      sd[4].bb   <= bb3;
      sd[4].wb   <= wb3;
      sd[4].zero <= (s3 == 64'd0);
      sd[4].lx   <= lx3;
      sd[4].ly   <= ly3;
      sd[4].lz   <= lz3;
      sd[4].tu   <= tu3;
      sd[4].tv   <= tv3;
      s4  <= s3;
      ax4 <= vaq_pkg::A_W'({ahx3, 32'd0}) + vaq_pkg::A_W'(alx3);
      ay4 <= vaq_pkg::A_W'({ahy3, 32'd0}) + vaq_pkg::A_W'(aly3);
      az4 <= vaq_pkg::A_W'({ahz3, 32'd0}) + vaq_pkg::A_W'(alz3);
      nx4 <= nx3;
      ny4 <= ny3;
      nz4 <= nz3;
    end
    for (int i = 5; i <= 12; i++) begin
      if (en[i]) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // Stages 5 to 12: byte search per component.
  logic [7:0] kx, ky, kz;

  vaq_nquant u_nq_x (.clk(clk), .en(en[12:5]), .s(s4), .a(ax4), .neg(nx4), .k(kx));
  vaq_nquant u_nq_y (.clk(clk), .en(en[12:5]), .s(s4), .a(ay4), .neg(ny4), .k(ky));
  vaq_nquant u_nq_z (.clk(clk), .en(en[12:5]), .s(s4), .a(az4), .neg(nz4), .k(kz));

  // Stage 13: packing into the output register.
  logic [63:0] res_next;
  logic        wide_next;
  logic [7:0]  top;
  logic [7:0]  bx, by, bz;

  always_comb begin
    bx  = sd[12].zero ? 8'd127 : kx;
    by  = sd[12].zero ? 8'd127 : ky;
    bz  = sd[12].zero ? 8'd127 : kz;
    top = (sd[12].kind == vaq_pkg::KIND_NORMAL) ?
          (sd[12].two ? sd[12].wb : sd[12].ba[7:0]) : 8'd0;
    res_next  = 64'd0;
    wide_next = 1'b0;
    unique case (sd[12].kind)
      vaq_pkg::KIND_POS: begin
        res_next  = {(sd[12].two ? 16'd1 : 16'd2730), sd[12].lz, sd[12].ly, sd[12].lx};
        wide_next = 1'b1;
      end
      vaq_pkg::KIND_NORMAL, vaq_pkg::KIND_TANGENT, vaq_pkg::KIND_BINORMAL: begin
        res_next = {32'd0, top, bx, by, bz};
      end
      vaq_pkg::KIND_TEXCOORD: begin
        res_next  = {(sd[12].two ? {1'b0, sd[12].bb, 1'b0, sd[12].ba} : 32'd0),
                     sd[12].tv, sd[12].tu};
        wide_next = sd[12].two;
      end
      default: begin
        res_next  = 64'd0;
        wide_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[13]) begin
      packed_res <= res_next;
      wide       <= wide_next;
    end
  end

  assign out_valid = v[vaq_pkg::NSTAGE-1];

  `include "vertex_attribute_quantizer_core_assert.svh"

  `VAQ_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)
  `VAQ_ASSERT_NOW(a_narrow_upper_zero, out_valid && !wide, packed_res[63:32] == 32'd0)
  `VAQ_ASSERT_NEXT(a_accept_fills_stage0, in_valid && in_ready, v[0])
  `VAQ_ASSERT_NOW(a_block_only_when_full, !in_ready, v[0] && out_valid)

endmodule
`default_nettype wire
